// File: hdl/gpc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// GPIO pin controller package
// Beat types, register word offsets, pull codes and controller commands.
// ---------------------------------------------------------------------------
package gpc_pkg;

   // Default configuration of the pin bank
   localparam int PIN_COUNT_DEF            = 54;
   localparam int SELECT_BITS_DEF          = 3;
   localparam int PINS_PER_SELECT_WORD_DEF = 10;

   // Fixed widths of the bus and the pin-facing fields
   localparam int OUT_PINS     = 54;
   localparam int DATA_W       = 32;
   localparam int INDEX_W      = 6;
   localparam int SELECT_WORDS = 6;

   // Access kinds
   localparam logic CMD_READ  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   // Register word offsets
   localparam logic [INDEX_W-1:0] WORD_SET0   = 6'd7;
   localparam logic [INDEX_W-1:0] WORD_SET1   = 6'd8;
   localparam logic [INDEX_W-1:0] WORD_CLR0   = 6'd10;
   localparam logic [INDEX_W-1:0] WORD_CLR1   = 6'd11;
   localparam logic [INDEX_W-1:0] WORD_LEV0   = 6'd13;
   localparam logic [INDEX_W-1:0] WORD_LEV1   = 6'd14;
   localparam logic [INDEX_W-1:0] WORD_PULL   = 6'd37;
   localparam logic [INDEX_W-1:0] WORD_PCLK0  = 6'd38;
   localparam logic [INDEX_W-1:0] WORD_PCLK1  = 6'd39;

   // Pull codes
   localparam logic [1:0] PULL_NONE = 2'd0;
   localparam logic [1:0] PULL_DOWN = 2'd1;
   localparam logic [1:0] PULL_UP   = 2'd2;

   // Request beat
   typedef struct packed {
      logic                command;
      logic [INDEX_W-1:0]  word_index;
      logic [DATA_W-1:0]   write_data;
      logic [OUT_PINS-1:0] pin_levels;
   } req_type;

   // Response beat
   typedef struct packed {
      logic [DATA_W-1:0]   read_data;
      logic                bad_offset;
      logic [OUT_PINS-1:0] drive_levels;
      logic [OUT_PINS-1:0] drive_enables;
      logic [OUT_PINS-1:0] pull_up_pins;
      logic [OUT_PINS-1:0] pull_down_pins;
   } rsp_type;

   // Controller to datapath commands
   typedef struct packed {
      logic capture;   // perform the access and load the response register
   } ctrl_cmd_type;

endpackage

// File: hdl/gpc_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// GPIO pin controller sequencer
// Tracks whether the response register holds a beat and issues the access
// command to the datapath.
// ---------------------------------------------------------------------------
module gpc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output gpc_pkg::ctrl_cmd_type cmd
);

   typedef enum logic {
      ST_EMPTY,
      ST_FULL
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      blocked;

   // Hold the request side only while an untaken response sits in the register
   assign blocked     = (state_ff == ST_FULL) && rsp_stall;
   assign req_stall   = blocked;
   assign cmd.capture = req_valid && !blocked;
   assign rsp_valid   = rsp_valid_ff;

   // Advance: a captured access fills the register, a taken beat empties it
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_EMPTY: begin
            if (cmd.capture) state_in = ST_FULL;
         end
         ST_FULL: begin
            if (cmd.capture)     state_in = ST_FULL;
            else if (!rsp_stall) state_in = ST_EMPTY;
         end
         default: state_in = ST_EMPTY;
      endcase
      rsp_valid_in = (state_in == ST_FULL);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_EMPTY;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: hdl/gpc_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// GPIO pin controller datapath
// Register words, output latch, per-pin pull codes and the response register.
// ---------------------------------------------------------------------------
module gpc_datapath #(
   parameter int PIN_COUNT            = gpc_pkg::PIN_COUNT_DEF,
   parameter int SELECT_BITS          = gpc_pkg::SELECT_BITS_DEF,
   parameter int PINS_PER_SELECT_WORD = gpc_pkg::PINS_PER_SELECT_WORD_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  gpc_pkg::ctrl_cmd_type cmd,
   input  gpc_pkg::req_type      req,
   output gpc_pkg::rsp_type      rsp
);

   localparam int FSEL_W = SELECT_BITS * PINS_PER_SELECT_WORD;
   localparam int DW     = gpc_pkg::DATA_W;
   localparam logic [63:0] PIN_MASK =
      (PIN_COUNT == 64) ? {64{1'b1}} : ((64'd1 << PIN_COUNT) - 64'd1);

   // Architectural state
   logic [FSEL_W-1:0]    fsel_ff [gpc_pkg::SELECT_WORDS];
   logic [FSEL_W-1:0]    fsel_mask [gpc_pkg::SELECT_WORDS];
   logic [PIN_COUNT-1:0] latch_ff, latch_in;
   logic [1:0]           pull_ctl_ff;
   logic [DW-1:0]        pclk_ff [2];
   logic [1:0]           pcode_ff [PIN_COUNT];

   // Response register
   logic [DW-1:0]        read_data_ff, read_data_in;
   logic                 bad_ff, bad_in;

   // Decode
   logic                 is_write;
   logic                 hit_fsel, hit_set, hit_clr, hit_lev, hit_pull, hit_pclk;
   logic [2:0]           fsel_idx;
   logic                 pclk_idx;
   logic [63:0]          data64, lat64, en64, lvl64, pins64, up64, down64;
   logic [PIN_COUNT-1:0] en, up, down;

   assign is_write = (req.command == gpc_pkg::CMD_WRITE);
   assign fsel_idx = req.word_index[2:0];
   assign pclk_idx = req.word_index[0];

   always_comb begin
      hit_fsel = 1'b0;
      hit_set  = 1'b0;
      hit_clr  = 1'b0;
      hit_lev  = 1'b0;
      hit_pull = 1'b0;
      hit_pclk = 1'b0;
      bad_in   = 1'b0;
      priority if (req.word_index < gpc_pkg::INDEX_W'(gpc_pkg::SELECT_WORDS)) begin
         hit_fsel = 1'b1;
      end else if (req.word_index == gpc_pkg::WORD_SET0 ||
                   req.word_index == gpc_pkg::WORD_SET1) begin
         hit_set = 1'b1;
      end else if (req.word_index == gpc_pkg::WORD_CLR0 ||
                   req.word_index == gpc_pkg::WORD_CLR1) begin
         hit_clr = 1'b1;
      end else if (req.word_index == gpc_pkg::WORD_LEV0 ||
                   req.word_index == gpc_pkg::WORD_LEV1) begin
         hit_lev = 1'b1;
      end else if (req.word_index == gpc_pkg::WORD_PULL) begin
         hit_pull = 1'b1;
      end else if (req.word_index == gpc_pkg::WORD_PCLK0 ||
                   req.word_index == gpc_pkg::WORD_PCLK1) begin
         hit_pclk = 1'b1;
      end else begin
         bad_in = 1'b1;
      end
   end

   // Keep only select fields of pins that exist
   for (genvar w = 0; w < gpc_pkg::SELECT_WORDS; w++) begin : g_mask_word
      for (genvar k = 0; k < PINS_PER_SELECT_WORD; k++) begin : g_mask_field
         if (w * PINS_PER_SELECT_WORD + k < PIN_COUNT) begin : g_on
            assign fsel_mask[w][k*SELECT_BITS +: SELECT_BITS] = {SELECT_BITS{1'b1}};
         end else begin : g_off
            assign fsel_mask[w][k*SELECT_BITS +: SELECT_BITS] = '0;
         end
      end
   end

   // Output enables: select code of one, pins past the select words stay inputs
   for (genvar p = 0; p < PIN_COUNT; p++) begin : g_pin
      if (p / PINS_PER_SELECT_WORD < gpc_pkg::SELECT_WORDS) begin : g_en
         assign en[p] = (fsel_ff[p / PINS_PER_SELECT_WORD]
                         [(p % PINS_PER_SELECT_WORD)*SELECT_BITS +: SELECT_BITS]
                         == SELECT_BITS'(1));
      end else begin : g_no_en
         assign en[p] = 1'b0;
      end
      assign up[p]   = (pcode_ff[p] == gpc_pkg::PULL_UP);
      assign down[p] = (pcode_ff[p] == gpc_pkg::PULL_DOWN);

      // Latch the pull code into pins selected by a pull clock write
      always_ff @(posedge clock) begin
         if (reset) begin
            pcode_ff[p] <= gpc_pkg::PULL_NONE;
         end else if (cmd.capture && is_write && hit_pclk &&
                      pclk_idx == 1'(p / 32) && req.write_data[p % 32]) begin
            pcode_ff[p] <= pull_ctl_ff;
         end
      end
   end

   // Widen pin vectors to the two-word level view
   assign lat64  = 64'(latch_ff);
   assign en64   = 64'(en);
   assign up64   = 64'(up);
   assign down64 = 64'(down);
   assign pins64 = 64'(req.pin_levels) & PIN_MASK;
   assign lvl64  = (lat64 & en64) | (pins64 & ~en64);
   assign data64 = (req.word_index == gpc_pkg::WORD_SET1 ||
                    req.word_index == gpc_pkg::WORD_CLR1)
                   ? {req.write_data, 32'd0} : {32'd0, req.write_data};

   // Set or clear the output latch
   always_comb begin
      latch_in = latch_ff;
      if (is_write && hit_set) latch_in = latch_ff | data64[PIN_COUNT-1:0];
      if (is_write && hit_clr) latch_in = latch_ff & ~data64[PIN_COUNT-1:0];
   end

   // Select the read word; writes return zero
   always_comb begin
      read_data_in = '0;
      if (!is_write) begin
         if (hit_fsel) read_data_in = DW'(fsel_ff[fsel_idx]);
         if (hit_lev)  read_data_in = (req.word_index == gpc_pkg::WORD_LEV1)
                                      ? lvl64[63:32] : lvl64[31:0];
         if (hit_pull) read_data_in = DW'(pull_ctl_ff);
         if (hit_pclk) read_data_in = pclk_ff[pclk_idx];
      end
   end

   // Update register words on a captured write
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < gpc_pkg::SELECT_WORDS; i++) fsel_ff[i] <= '0;
         latch_ff    <= '0;
         pull_ctl_ff <= gpc_pkg::PULL_NONE;
         pclk_ff[0]  <= '0;
         pclk_ff[1]  <= '0;
      end else if (cmd.capture) begin
         latch_ff <= latch_in;
         if (is_write && hit_fsel)
            fsel_ff[fsel_idx] <= req.write_data[FSEL_W-1:0] & fsel_mask[fsel_idx];
         if (is_write && hit_pull) pull_ctl_ff <= req.write_data[1:0];
         if (is_write && hit_pclk) pclk_ff[pclk_idx] <= req.write_data;
      end
   end

   // Load the response register
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         read_data_ff <= read_data_in;
         bad_ff       <= bad_in;
      end
   end

   // Pin outputs follow state, which holds while a response waits
   assign rsp.read_data      = read_data_ff;
   assign rsp.bad_offset     = bad_ff;
   assign rsp.drive_levels   = lat64[gpc_pkg::OUT_PINS-1:0];
   assign rsp.drive_enables  = en64[gpc_pkg::OUT_PINS-1:0];
   assign rsp.pull_up_pins   = up64[gpc_pkg::OUT_PINS-1:0];
   assign rsp.pull_down_pins = down64[gpc_pkg::OUT_PINS-1:0];

endmodule

// File: hdl/gpio_pin_controller.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// GPIO pin controller
// Register-mapped controller for a bank of pins: function select, output
// set and clear, level read, and latched pull configuration.
// ---------------------------------------------------------------------------
//
//  Channel   Ports                              Beat
//  request   req_valid, req_stall, req_payload  one register read or write
//  response  rsp_valid, rsp_stall, rsp_payload  read word, flag, pin state
//
//  One access per cycle: the access is performed at the accepting edge and
//  its response appears in the response register on the next cycle.
//  A waiting response can be taken in the same cycle as the next request.
//  Requests stall only while a response is held by rsp_stall.
//  Synchronous reset clears all register words, the latch and pull codes.
// ---------------------------------------------------------------------------
module gpio_pin_controller #(
   parameter int PIN_COUNT            = gpc_pkg::PIN_COUNT_DEF,
   parameter int SELECT_BITS          = gpc_pkg::SELECT_BITS_DEF,
   parameter int PINS_PER_SELECT_WORD = gpc_pkg::PINS_PER_SELECT_WORD_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  gpc_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output gpc_pkg::rsp_type rsp_payload
);

   gpc_pkg::ctrl_cmd_type cmd;

   gpc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   gpc_datapath #(
      .PIN_COUNT            (PIN_COUNT),
      .SELECT_BITS          (SELECT_BITS),
      .PINS_PER_SELECT_WORD (PINS_PER_SELECT_WORD)
   ) u_datapath (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .req   (req_payload),
      .rsp   (rsp_payload)
   );

endmodule

// File: dv/tb_gpio_pin_controller.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// GPIO pin controller testbench
// Drives register reads and writes into the controller and checks every
// response beat against an in-bench model of the register words, output
// latch and pull latches. A directed run over the map's corners precedes
// random accesses; both channels idle and stall in random bursts.
// ---------------------------------------------------------------------------
module tb_gpio_pin_controller;

   localparam int PINS = gpc_pkg::PIN_COUNT_DEF;

   // Access waiting to be offered; drain_first holds it until all replies land
   typedef struct packed {
      logic             drain_first;
      gpc_pkg::req_type beat;
   } queued_access_type;

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             req_valid   = 1'b0;
   logic             req_stall;
   gpc_pkg::req_type req_payload = '0;
   logic             rsp_valid;
   logic             rsp_stall   = 1'b0;
   gpc_pkg::rsp_type rsp_payload;

   queued_access_type access_backlog[$];
   gpc_pkg::rsp_type  expected_replies[$];
   queued_access_type next_access;

   // Model state of the pin bank
   logic [gpc_pkg::DATA_W-1:0]   sel_words [gpc_pkg::SELECT_WORDS];
   logic [gpc_pkg::OUT_PINS-1:0] out_latch;
   logic [1:0]                   pull_ctl;
   logic [gpc_pkg::DATA_W-1:0]   pull_clock_words [2];
   logic [1:0]                   pin_pull [PINS];

   int   mismatch_count = 0;
   int   beats_checked  = 0;
   int   cycle_count    = 0;
   logic req_beat_taken = 1'b0;
   int   send_gap       = 0;
   int   recv_stall     = 0;
   logic long_hold_done = 1'b0;

   gpio_pin_controller u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Output enables from the function select fields: code 1 means output
   function automatic logic [gpc_pkg::OUT_PINS-1:0] output_enables();
      logic [gpc_pkg::OUT_PINS-1:0] en;
      int w;
      int k;
      en = '0;
      for (int p = 0; p < PINS; p++) begin
         w = p / gpc_pkg::PINS_PER_SELECT_WORD_DEF;
         k = p % gpc_pkg::PINS_PER_SELECT_WORD_DEF;
         if (w < gpc_pkg::SELECT_WORDS &&
             sel_words[w][k*gpc_pkg::SELECT_BITS_DEF +: gpc_pkg::SELECT_BITS_DEF] == 3'd1)
            en[p] = 1'b1;
      end
      return en;
   endfunction

   // Perform one register access on the model and return the response beat
   function automatic gpc_pkg::rsp_type apply_access(input gpc_pkg::req_type a);
      gpc_pkg::rsp_type             r;
      logic [63:0]                  bits;
      logic [63:0]                  lv;
      logic [gpc_pkg::OUT_PINS-1:0] en;
      logic [gpc_pkg::DATA_W-1:0]   keep;
      int                           c;
      int                           pin;
      r = '0;
      case (a.word_index)
         gpc_pkg::WORD_SET0, gpc_pkg::WORD_SET1,
         gpc_pkg::WORD_CLR0, gpc_pkg::WORD_CLR1: begin
            if (a.command == gpc_pkg::CMD_WRITE) begin
               if (a.word_index == gpc_pkg::WORD_SET1 || a.word_index == gpc_pkg::WORD_CLR1)
                  bits = {a.write_data, 32'h0};
               else
                  bits = {32'h0, a.write_data};
               bits = bits & ((64'd1 << PINS) - 64'd1);
               if (a.word_index == gpc_pkg::WORD_SET0 || a.word_index == gpc_pkg::WORD_SET1)
                  out_latch = out_latch | bits[gpc_pkg::OUT_PINS-1:0];
               else
                  out_latch = out_latch & ~bits[gpc_pkg::OUT_PINS-1:0];
            end
         end
         gpc_pkg::WORD_LEV0, gpc_pkg::WORD_LEV1: begin
            if (a.command == gpc_pkg::CMD_READ) begin
               en = output_enables();
               lv = {10'd0, (out_latch & en) | (a.pin_levels & ~en)};
               lv = lv & ((64'd1 << PINS) - 64'd1);
               r.read_data = (a.word_index == gpc_pkg::WORD_LEV1) ? lv[63:32] : lv[31:0];
            end
         end
         gpc_pkg::WORD_PULL: begin
            if (a.command == gpc_pkg::CMD_WRITE)
               pull_ctl = a.write_data[1:0];
            else
               r.read_data = {30'd0, pull_ctl};
         end
         gpc_pkg::WORD_PCLK0, gpc_pkg::WORD_PCLK1: begin
            c = (a.word_index == gpc_pkg::WORD_PCLK1) ? 1 : 0;
            if (a.command == gpc_pkg::CMD_WRITE) begin
               pull_clock_words[c] = a.write_data;
               for (int b = 0; b < 32; b++) begin
                  pin = c * 32 + b;
                  if (a.write_data[b] && pin < PINS)
                     pin_pull[pin] = pull_ctl;
               end
            end else begin
               r.read_data = pull_clock_words[c];
            end
         end
         default: begin
            if (a.word_index < gpc_pkg::SELECT_WORDS) begin
               // keep only the fields of pins that exist
               keep = '0;
               for (int k = 0; k < gpc_pkg::PINS_PER_SELECT_WORD_DEF; k++)
                  if (a.word_index * gpc_pkg::PINS_PER_SELECT_WORD_DEF + k < PINS)
                     keep = keep | (32'h7 << (k * gpc_pkg::SELECT_BITS_DEF));
               if (a.command == gpc_pkg::CMD_WRITE)
                  sel_words[a.word_index[2:0]] = a.write_data & keep;
               else
                  r.read_data = sel_words[a.word_index[2:0]];
            end else begin
               r.bad_offset = 1'b1;
            end
         end
      endcase
      if (a.command == gpc_pkg::CMD_WRITE)
         r.read_data = '0;
      r.drive_levels  = out_latch;
      r.drive_enables = output_enables();
      for (int p = 0; p < PINS; p++) begin
         if (pin_pull[p] == gpc_pkg::PULL_UP)
            r.pull_up_pins[p] = 1'b1;
         else if (pin_pull[p] == gpc_pkg::PULL_DOWN)
            r.pull_down_pins[p] = 1'b1;
      end
      return r;
   endfunction

   task automatic compare_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %h, got %h", name, want, got);
         mismatch_count++;
      end
   endtask

   task automatic queue_access(input logic cmd, input logic [gpc_pkg::INDEX_W-1:0] idx,
                               input logic [gpc_pkg::DATA_W-1:0] data,
                               input logic [gpc_pkg::OUT_PINS-1:0] pins, input logic drain);
      queued_access_type q;
      q.drain_first     = drain;
      q.beat.command    = cmd;
      q.beat.word_index = idx;
      q.beat.write_data = data;
      q.beat.pin_levels = pins;
      access_backlog.push_back(q);
   endtask

   // Random access, mostly to mapped words, select writes biased to outputs
   function automatic gpc_pkg::req_type random_access();
      gpc_pkg::req_type a;
      int               pick;
      pick = $urandom_range(0, 17);
      case (pick)
         6:  a.word_index = gpc_pkg::WORD_SET0;
         7:  a.word_index = gpc_pkg::WORD_SET1;
         8:  a.word_index = gpc_pkg::WORD_CLR0;
         9:  a.word_index = gpc_pkg::WORD_CLR1;
         10: a.word_index = gpc_pkg::WORD_LEV0;
         11: a.word_index = gpc_pkg::WORD_LEV1;
         12: a.word_index = gpc_pkg::WORD_PULL;
         13: a.word_index = gpc_pkg::WORD_PCLK0;
         14: a.word_index = gpc_pkg::WORD_PCLK1;
         15, 16, 17: a.word_index = gpc_pkg::INDEX_W'($urandom_range(0, 63));
         default: a.word_index = gpc_pkg::INDEX_W'(pick);
      endcase
      a.command = ($urandom_range(0, 9) < 6) ? gpc_pkg::CMD_WRITE : gpc_pkg::CMD_READ;
      pick = $urandom_range(0, 7);
      if (pick == 0)
         a.write_data = '1;
      else if (pick == 1)
         a.write_data = '0;
      else
         a.write_data = $urandom;
      if (a.word_index < gpc_pkg::SELECT_WORDS && $urandom_range(0, 3) != 0)
         for (int k = 0; k < gpc_pkg::PINS_PER_SELECT_WORD_DEF; k++)
            a.write_data[k*3 +: 3] = $urandom_range(0, 1) ? 3'd1 : 3'($urandom_range(0, 7));
      a.pin_levels = gpc_pkg::OUT_PINS'({$urandom, $urandom});
      return a;
   endfunction

   // Idling only outside the tail and in three of every four windows
   function automatic bit idle_allowed();
      return access_backlog.size() > 60 && (cycle_count / 100) % 4 != 3;
   endfunction

   // Request driver: advance on an accepted beat, hold otherwise
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_beat_taken) begin
         if (send_gap != 0) begin
            send_gap  <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (idle_allowed() && $urandom_range(0, 7) == 0) begin
            send_gap  <= $urandom_range(0, 10);
            req_valid <= 1'b0;
         end else if (access_backlog.size() != 0 &&
                      !(access_backlog[0].drain_first && expected_replies.size() != 0)) begin
            next_access = access_backlog.pop_front();
            req_payload <= next_access.beat;
            req_valid   <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response receiver: random stall bursts and one long hold-off
   always @(negedge clock) begin
      if (recv_stall != 0) begin
         recv_stall <= recv_stall - 1;
         rsp_stall  <= 1'b1;
      end else if (!long_hold_done && beats_checked >= 150) begin
         long_hold_done <= 1'b1;
         recv_stall     <= 79;
         rsp_stall      <= 1'b1;
      end else if (idle_allowed() && $urandom_range(0, 7) == 0) begin
         recv_stall <= $urandom_range(0, 10);
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Monitor: check the response beat, then record the accepted request
   always @(posedge clock) begin
      gpc_pkg::rsp_type want;
      cycle_count    <= cycle_count + 1;
      req_beat_taken <= !reset && req_valid && !req_stall;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_replies.size() == 0) begin
               $error("unexpected response beat: read_data %h", rsp_payload.read_data);
               mismatch_count++;
            end else begin
               want = expected_replies.pop_front();
               compare_field("read_data", 64'(want.read_data),
                             64'(rsp_payload.read_data));
               compare_field("bad_offset", 64'(want.bad_offset),
                             64'(rsp_payload.bad_offset));
               compare_field("drive_levels", 64'(want.drive_levels),
                             64'(rsp_payload.drive_levels));
               compare_field("drive_enables", 64'(want.drive_enables),
                             64'(rsp_payload.drive_enables));
               compare_field("pull_up_pins", 64'(want.pull_up_pins),
                             64'(rsp_payload.pull_up_pins));
               compare_field("pull_down_pins", 64'(want.pull_down_pins),
                             64'(rsp_payload.pull_down_pins));
            end
            beats_checked <= beats_checked + 1;
         end
         if (req_valid && !req_stall)
            expected_replies.push_back(apply_access(req_payload));
      end
   end

   initial begin
      gpc_pkg::req_type a;
      int               drain_wait;
      // clear the model to its reset state
      for (int w = 0; w < gpc_pkg::SELECT_WORDS; w++)
         sel_words[w] = '0;
      for (int p = 0; p < PINS; p++)
         pin_pull[p] = gpc_pkg::PULL_NONE;
      out_latch           = '0;
      pull_ctl            = gpc_pkg::PULL_NONE;
      pull_clock_words[0] = '0;
      pull_clock_words[1] = '0;

      // directed corners: reset reads, field masks, latch edges, pull codes
      queue_access(gpc_pkg::CMD_READ,  6'd0, '0, '1, 1'b0);
      queue_access(gpc_pkg::CMD_WRITE, 6'd0, '1, '0, 1'b0);
      queue_access(gpc_pkg::CMD_READ,  6'd0, '0, '0, 1'b0);
      queue_access(gpc_pkg::CMD_WRITE, 6'd5, '1, '0, 1'b0);
      queue_access(gpc_pkg::CMD_READ,  6'd5, '0, '0, 1'b0);
      queue_access(gpc_pkg::CMD_WRITE, 6'd0, 32'h0924_9249, '0, 1'b0);
      queue_access(gpc_pkg::CMD_WRITE, 6'd5, 32'h0000_0249, '0, 1'b0);
      queue_access(gpc_pkg::CMD_WRITE, gpc_pkg::WORD_SET0,  '1, '0, 1'b0);
      queue_access(gpc_pkg::CMD_WRITE, gpc_pkg::WORD_SET1,  '1, '0, 1'b0);
      queue_access(gpc_pkg::CMD_READ,  gpc_pkg::WORD_LEV0,  '1, '0, 1'b0);
      queue_access(gpc_pkg::CMD_READ,  gpc_pkg::WORD_LEV1,  '0, '1, 1'b0);
      queue_access(gpc_pkg::CMD_READ,  gpc_pkg::WORD_SET0,  '0, '0, 1'b0);
      queue_access(gpc_pkg::CMD_WRITE, gpc_pkg::WORD_LEV0,  '1, '1, 1'b0);
      queue_access(gpc_pkg::CMD_WRITE, gpc_pkg::WORD_CLR0,  32'hAAAA_AAAA, '0, 1'b0);
      queue_access(gpc_pkg::CMD_WRITE, gpc_pkg::WORD_CLR1,  '1, '0, 1'b0);
      queue_access(gpc_pkg::CMD_WRITE, gpc_pkg::WORD_PULL,  '1, '0, 1'b0);
      queue_access(gpc_pkg::CMD_WRITE, gpc_pkg::WORD_PCLK0, 32'h0000_0001, '0, 1'b0);
      queue_access(gpc_pkg::CMD_WRITE, gpc_pkg::WORD_PULL,
                   {30'd0, gpc_pkg::PULL_UP}, '0, 1'b0);
      queue_access(gpc_pkg::CMD_WRITE, gpc_pkg::WORD_PCLK1, '1, '0, 1'b0);
      queue_access(gpc_pkg::CMD_READ,  gpc_pkg::WORD_PCLK1, '0, '0, 1'b0);
      queue_access(gpc_pkg::CMD_WRITE, gpc_pkg::WORD_PULL,
                   {30'd0, gpc_pkg::PULL_DOWN}, '0, 1'b0);
      queue_access(gpc_pkg::CMD_WRITE, gpc_pkg::WORD_PCLK0, 32'hFFFF_FFFE, '0, 1'b0);
      queue_access(gpc_pkg::CMD_READ,  gpc_pkg::WORD_PULL,  '1, '0, 1'b0);
      queue_access(gpc_pkg::CMD_READ,  6'd6,  '0, '0, 1'b0);
      queue_access(gpc_pkg::CMD_WRITE, 6'd63, '1, '1, 1'b0);

      // random accesses, with a drain pause every so often
      for (int i = 0; i < 725; i++) begin
         a = random_access();
         queue_access(a.command, a.word_index, a.write_data, a.pin_levels,
                      (i % 150) == 149);
      end

      repeat (8) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // hold until every access is offered and accepted, then drain replies
      while (access_backlog.size() != 0 || req_valid)
         @(posedge clock);
      drain_wait = 0;
      while (expected_replies.size() != 0 && drain_wait < 1000) begin
         @(posedge clock);
         drain_wait++;
      end
      if (expected_replies.size() != 0) begin
         $error("%0d response beats never arrived", expected_replies.size());
         mismatch_count++;
      end
      repeat (5) @(posedge clock);
      if (mismatch_count == 0)
         $display("gpio_pin_controller regression: pass");
      else
         $display("gpio_pin_controller regression: fail");
      $finish;
   end

   // Watchdog
   initial begin
      #5_000_000;
      $display("gpio_pin_controller regression: fail");
      $finish;
   end

endmodule

// File: gpio_pin_controller.f
hdl/gpc_pkg.sv
hdl/gpc_ctrl.sv
hdl/gpc_datapath.sv
hdl/gpio_pin_controller.sv
dv/tb_gpio_pin_controller.sv
